@@ rtl/core/srlp_pkg.sv @@
package srlp_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [9:0] POS_MAX = 10'd1023;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;

  localparam logic [3:0] REC_S0    = 4'd0;
  localparam logic [3:0] REC_S2    = 4'd2;
  localparam logic [3:0] REC_S3    = 4'd3;
  localparam logic [3:0] REC_S4    = 4'd4;
  localparam logic [3:0] REC_S6    = 4'd6;
  localparam logic [3:0] REC_S7    = 4'd7;
  localparam logic [3:0] REC_S8    = 4'd8;
  localparam logic [3:0] REC_S9    = 4'd9;
  localparam logic [3:0] REC_UNSUP = 4'd15;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_TEXT,
    KIND_DONE
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_HEX,
    ST_PROTECTED,
    ST_UNSUPPORTED
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    status_t     status;
    logic        is_entry;
  } result_t;

  // bit 4 set marks a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'h10;
      if (c inside {[CH_0:CH_9]}) begin
        v = c - CH_0;
      end else if (c inside {[CH_LA:CH_LF]}) begin
        v = c - CH_LA + 8'd10;
      end else if (c inside {[CH_UA:CH_UF]}) begin
        v = c - CH_UA + 8'd10;
      end
      return v[4:0];
    end
  endfunction

  function automatic logic [2:0] addr_len(input logic [3:0] t);
    logic [2:0] n;
    begin
      n = 3'd2;
      if (t inside {REC_S2, REC_S8}) begin
        n = 3'd3;
      end else if (t inside {REC_S3, REC_S7}) begin
        n = 3'd4;
      end
      return n;
    end
  endfunction

  function automatic logic is_term(input logic [3:0] t);
    return t inside {REC_S7, REC_S8, REC_S9};
  endfunction

  function automatic logic [7:0] data_count(input logic [3:0] t, input logic [7:0] cnt);
    logic [7:0] need;
    begin
      need = {5'd0, addr_len(t)} + 8'd1;
      return (cnt > need) ? (cnt - need) : 8'd0;
    end
  endfunction

endpackage

@@ rtl/core/srlp_parse.sv @@
module srlp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [7:0]           char_code,
  input  logic                 last_of_record,
  input  logic [31:0]          protect_limit,
  output logic [1:0]           res_n,
  output srlp_pkg::result_t    res0,
  output srlp_pkg::result_t    res1
);
  import srlp_pkg::*;

  logic [9:0]  pos_r, pos_nxt;
  logic [3:0]  rtype_r, rtype_nxt;
  logic [7:0]  bcount_r, bcount_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [3:0]  hnib_r, hnib_nxt;
  status_t     err_r, err_nxt;

  logic [4:0]  hv;
  logic        bad;
  logic [3:0]  dig;
  logic [7:0]  byte_v;
  logic [2:0]  al;
  logic        term;
  logic [9:0]  pm4;
  logic [8:0]  k;
  logic [8:0]  j;
  logic        second;
  logic [7:0]  dc;
  logic [31:0] addr_shift;
  logic        emit;
  result_t     data_res;
  result_t     done_res;

  logic [2:0]  al2;
  logic        term2;
  logic [7:0]  dc2;
  logic [9:0]  need;
  logic        short_rec;
  status_t     st;

  always_comb begin
    hv         = hex_value(char_code);
    bad        = hv[4];
    dig        = hv[3:0];
    byte_v     = {hnib_r, dig};
    al         = addr_len(rtype_r);
    term       = is_term(rtype_r);
    pm4        = pos_r - 10'd4;
    k          = pm4[9:1];
    second     = pm4[0];
    j          = k - {6'd0, al};
    dc         = data_count(rtype_r, bcount_r);
    addr_shift = {addr_r[23:0], byte_v};

    pos_nxt    = (pos_r < POS_MAX) ? pos_r + 10'd1 : POS_MAX;
    rtype_nxt  = rtype_r;
    bcount_nxt = bcount_r;
    addr_nxt   = addr_r;
    hnib_nxt   = hnib_r;
    err_nxt    = err_r;
    emit       = 1'b0;

    if (pos_r == 10'd1) begin
      if (bad || dig > 4'd9 || (dig inside {[REC_S4:REC_S6]})) begin
        rtype_nxt = REC_UNSUP;
        err_nxt   = ST_UNSUPPORTED;
      end else begin
        rtype_nxt = dig;
      end
    end else if (pos_r >= 10'd2 && err_r == ST_OK) begin
      if (pos_r < 10'd4) begin
        if (!term) begin
          if (bad) begin
            err_nxt = ST_BAD_HEX;
          end else if (pos_r == 10'd2) begin
            hnib_nxt = dig;
          end else begin
            bcount_nxt = byte_v;
          end
        end
      end else if (k < {6'd0, al}) begin
        if (rtype_r != REC_S0) begin
          if (bad) begin
            err_nxt = ST_BAD_HEX;
          end else if (!second) begin
            hnib_nxt = dig;
          end else begin
            addr_nxt = addr_shift;
            if (k == {6'd0, al - 3'd1} && !term && addr_shift < protect_limit) begin
              err_nxt = ST_PROTECTED;
            end
          end
        end
      end else if (!term && j < {1'b0, dc}) begin
        if (bad) begin
          err_nxt = ST_BAD_HEX;
        end else if (!second) begin
          hnib_nxt = dig;
        end else begin
          emit = 1'b1;
        end
      end
    end

    data_res.kind      = (rtype_r == REC_S0) ? KIND_TEXT : KIND_WRITE;
    data_res.address   = (rtype_r == REC_S0) ? 32'd0 : addr_r + {23'd0, j};
    data_res.data_byte = byte_v;
    data_res.status    = ST_OK;
    data_res.is_entry  = 1'b0;

    al2   = addr_len(rtype_nxt);
    term2 = is_term(rtype_nxt);
    dc2   = data_count(rtype_nxt, bcount_nxt);
    if (term2) begin
      need = 10'd4 + {6'd0, al2, 1'b0};
    end else begin
      need = 10'd4 + {({6'd0, al2} + {1'b0, dc2}), 1'b0};
    end
    short_rec = (pos_r == 10'd0) || (({1'b0, pos_r} + 11'd1) < {1'b0, need});
    st = (err_nxt == ST_OK && short_rec) ? ST_BAD_HEX : err_nxt;

    done_res.kind      = KIND_DONE;
    done_res.data_byte = 8'd0;
    if (st == ST_OK && term2) begin
      done_res.address  = addr_nxt;
      done_res.status   = ST_OK;
      done_res.is_entry = 1'b1;
    end else begin
      done_res.address  = 32'd0;
      done_res.status   = st;
      done_res.is_entry = 1'b0;
    end

    if (!adv) begin
      res_n = 2'd0;
    end else begin
      res_n = {1'b0, emit} + {1'b0, last_of_record};
    end
    res0 = emit ? data_res : done_res;
    res1 = done_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      rtype_r  <= '0;
      bcount_r <= '0;
      addr_r   <= '0;
      hnib_r   <= '0;
      err_r    <= ST_OK;
    end else if (adv) begin
      if (last_of_record) begin
        pos_r    <= '0;
        rtype_r  <= '0;
        bcount_r <= '0;
        addr_r   <= '0;
        hnib_r   <= '0;
        err_r    <= ST_OK;
      end else begin
        pos_r    <= pos_nxt;
        rtype_r  <= rtype_nxt;
        bcount_r <= bcount_nxt;
        addr_r   <= addr_nxt;
        hnib_r   <= hnib_nxt;
        err_r    <= err_nxt;
      end
    end
  end

endmodule

@@ rtl/core/srlp_outq.sv @@
module srlp_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_n,
  input  srlp_pkg::result_t    push0,
  input  srlp_pkg::result_t    push1,
  output logic                 room2,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srlp_pkg::result_t    out_res
);
  import srlp_pkg::*;

  result_t          mem [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             pop;

  always_comb begin
    out_valid = (cnt_r != '0);
    out_res   = mem[rp_r];
    pop       = out_valid && out_ready;
    room2     = (cnt_r <= QCW'(QDEPTH - 2));
    wp_nxt    = wp_r + QAW'(push_n);
    rp_nxt    = pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt   = cnt_r + QCW'(push_n) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wp_r + QAW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/srecord_loader_parser.sv @@
// S-record loader parser.
// Input stream: one ASCII character per word on in_tdata, in_tlast on the
// final character of a record line. Each character may yield a memory write
// (S1/S2/S3 data) or a header text byte (S0 data); the last character also
// yields a record done word carrying status and, for S7/S8/S9, the entry
// address. Output words appear on out_tdata with the kind on out_tuser.
// cfg_data writes the protection limit; cfg_ready is always high, and the
// limit should change only while no record is in flight.
// Path: a character is held in the input register, then parsed and written
// into a four-word result queue whose head drives the output. Throughput:
// one character per cycle while the receiver takes one word per cycle; a
// character that closes a record with a data byte produces two words. The
// input register advances only while the queue has room for two words, so
// a stalled receiver backs up into in_tready after the queue fills.
// Reset (synchronous, rst_n low) clears the parse state, empties the queue
// and sets the protection limit to zero.
module srecord_loader_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,     // protect_limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // char_code
  input  logic        in_tlast,     // last_of_record
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // address[31:0], data_byte[39:32], status[41:40],
                                    // is_entry[42], zero fill
  output logic [1:0]  out_tuser     // kind
);
  import srlp_pkg::*;

  logic [31:0] limit_r;
  logic        in_v_r;
  logic [7:0]  in_char_r;
  logic        in_last_r;
  logic        adv;
  logic        room2;
  logic [1:0]  res_n;
  result_t     res0;
  result_t     res1;
  result_t     head;

  assign cfg_ready = 1'b1;
  assign adv       = in_v_r && room2;
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  srlp_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .char_code      (in_char_r),
    .last_of_record (in_last_r),
    .protect_limit  (limit_r),
    .res_n          (res_n),
    .res0           (res0),
    .res1           (res1)
  );

  srlp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (res_n),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign out_tdata = {5'd0, head.is_entry, head.status, head.data_byte, head.address};
  assign out_tuser = head.kind;

`ifndef NO_ASSERTIONS
  a_entry_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[42] |-> out_tuser == KIND_DONE && out_tdata[41:40] == ST_OK)
    else $error("entry flag on a word that is not an ok done");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DONE |-> out_tdata[41:40] == ST_OK && !out_tdata[42])
    else $error("status or entry flag set on a data word");

  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(in_char_r) && $stable(in_last_r))
    else $error("input register lost a stalled character");
`endif

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  import srlp_pkg::*;

  localparam logic [3:0] REC_S1 = 4'd1;
  localparam int WATCHDOG = 500;
  localparam int SETTLE = 8;

  typedef enum int {
    MUT_NONE,
    MUT_CUT,
    MUT_BAD_CHAR,
    MUT_COUNT,
    MUT_TRAIL,
    MUT_TYPE,
    MUT_LEAD
  } flaw_t;

  class loader_scoreboard;
    logic [31:0] limit = '0;
    int          pos = 0;
    logic [3:0]  rtype = '0;
    logic [7:0]  count = '0;
    logic [31:0] addr = '0;
    logic [3:0]  hi = '0;
    status_t     err = ST_OK;
    result_t     parsed_words[$];
    int          errors = 0;

    function int nibble_of(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return c - CH_0;
      if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
      if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
      return 16;
    endfunction

    function int addr_bytes(logic [3:0] t);
      if (t == REC_S2 || t == REC_S8) return 3;
      if (t == REC_S3 || t == REC_S7) return 4;
      return 2;
    endfunction

    function bit is_termination(logic [3:0] t);
      return t == REC_S7 || t == REC_S8 || t == REC_S9;
    endfunction

    function int payload_len(logic [3:0] t);
      int need;
      need = addr_bytes(t) + 1;
      return (count > need) ? count - need : 0;
    endfunction

    function bit take_nibble(logic [7:0] c, bit second, output logic [7:0] b);
      int d;
      d = nibble_of(c);
      b = '0;
      if (d > 15) begin
        err = ST_BAD_HEX;
        return 0;
      end
      if (!second) begin
        hi = d[3:0];
        return 0;
      end
      b = {hi, d[3:0]};
      return 1;
    endfunction

    function void add(kind_t k, logic [31:0] a, logic [7:0] b, status_t st, logic ent);
      result_t r;
      r.kind = k;
      r.address = a;
      r.data_byte = b;
      r.status = st;
      r.is_entry = ent;
      parsed_words.push_back(r);
    endfunction

    function void parse_char(logic [7:0] c, logic last);
      int p, k, j, al, d, need;
      logic [3:0] t;
      logic [7:0] b;
      bit second;
      status_t st;
      p = pos;
      t = rtype;
      if (p == 1) begin
        d = nibble_of(c);
        if (d > REC_S9 || (d >= REC_S4 && d <= REC_S6)) begin
          rtype = REC_UNSUP;
          err = ST_UNSUPPORTED;
        end else begin
          rtype = d[3:0];
        end
      end else if (p >= 2 && err == ST_OK) begin
        if (p < 4) begin
          if (!is_termination(t) && take_nibble(c, p == 3, b)) count = b;
        end else begin
          k = (p - 4) / 2;
          second = ((p - 4) % 2) != 0;
          al = addr_bytes(t);
          if (k < al) begin
            if (t != REC_S0 && take_nibble(c, second, b)) begin
              addr = {addr[23:0], b};
              if (k == al - 1 && !is_termination(t) && addr < limit) err = ST_PROTECTED;
            end
          end else if (!is_termination(t)) begin
            j = k - al;
            if (j < payload_len(t) && take_nibble(c, second, b)) begin
              if (t == REC_S0) add(KIND_TEXT, '0, b, ST_OK, 1'b0);
              else add(KIND_WRITE, addr + j, b, ST_OK, 1'b0);
            end
          end
        end
      end
      pos = (p < POS_MAX) ? p + 1 : POS_MAX;
      if (last) begin
        st = err;
        if (st == ST_OK) begin
          if (p < 1) need = 2;
          else if (is_termination(rtype)) need = 4 + 2 * addr_bytes(rtype);
          else need = 4 + 2 * (addr_bytes(rtype) + payload_len(rtype));
          if (p + 1 < need) st = ST_BAD_HEX;
        end
        if (st == ST_OK && is_termination(rtype)) add(KIND_DONE, addr, '0, ST_OK, 1'b1);
        else add(KIND_DONE, '0, '0, st, 1'b0);
        pos = 0;
        rtype = '0;
        count = '0;
        addr = '0;
        hi = '0;
        err = ST_OK;
      end
    endfunction

    function void check_word(logic [1:0] kind, logic [47:0] word);
      result_t e;
      if (parsed_words.size() == 0) begin
        $error("unexpected word: kind %0d tdata %0h", kind, word);
        errors++;
        return;
      end
      e = parsed_words.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, kind);
        errors++;
      end
      if (word[31:0] !== e.address) begin
        $error("address: expected %0h actual %0h", e.address, word[31:0]);
        errors++;
      end
      if (word[39:32] !== e.data_byte) begin
        $error("data_byte: expected %0h actual %0h", e.data_byte, word[39:32]);
        errors++;
      end
      if (word[41:40] !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, word[41:40]);
        errors++;
      end
      if (word[42] !== e.is_entry) begin
        $error("is_entry: expected %0d actual %0d", e.is_entry, word[42]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  loader_scoreboard sb = new;
  bit               calm = 1'b0;
  bit               sender_gaps = 1'b1;
  logic [31:0]      cur_limit = '0;
  byte unsigned     line[$];
  int               chars_sent = 0;

  always #1 clk = ~clk;

  srecord_loader_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.limit = cfg_data;
      if (in_tvalid && in_tready) sb.parse_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_word(out_tuser, out_tdata);
    end
  end

  initial begin : sink
    int k;
    int n;
    bit stalls;
    n = 0;
    stalls = 1'b1;
    forever begin
      @(negedge clk);
      n++;
      if (n % 40 == 0) stalls = $urandom_range(0, 2) != 0;
      if (!calm && stalls && $urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, 9);
        out_tready <= 1'b0;
        repeat (k - 1) @(negedge clk);
        n += k - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic byte unsigned hex_char(logic [3:0] n);
    if (n < 10) return CH_0 + n;
    return 8'((($urandom_range(0, 1) == 1) ? CH_LA : CH_UA) + n - 10);
  endfunction

  function automatic void push_byte(logic [7:0] v);
    line.push_back(hex_char(v[7:4]));
    line.push_back(hex_char(v[3:0]));
  endfunction

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void compose(logic [3:0] t, int ndata, logic [31:0] a);
    int al;
    logic [7:0] sum, v;
    al = sb.addr_bytes(t);
    if (sb.is_termination(t)) ndata = 0;
    line.delete();
    line.push_back("S");
    line.push_back(CH_0 + t);
    sum = 8'(al + ndata + 1);
    push_byte(sum);
    for (int i = al - 1; i >= 0; i--) begin
      v = a[8*i +: 8];
      sum += v;
      push_byte(v);
    end
    for (int i = 0; i < ndata; i++) begin
      v = rand_data();
      sum += v;
      push_byte(v);
    end
    push_byte(~sum);
  endfunction

  function automatic logic [31:0] pick_addr(int al);
    logic [31:0] a, mask;
    mask = (al == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * al)) - 1);
    case ($urandom_range(0, 4))
      0: a = $urandom;
      1: a = cur_limit;
      2: a = cur_limit - 1;
      3: a = 32'hFFFF_FFFF;
      default: a = '0;
    endcase
    return a & mask;
  endfunction

  function automatic void apply_flaw(flaw_t f);
    int at;
    case (f)
      MUT_CUT: begin
        at = $urandom_range(1, line.size() - 1);
        while (line.size() > at) void'(line.pop_back());
      end
      MUT_BAD_CHAR: begin
        at = $urandom_range(1, line.size() - 1);
        line[at] = 8'($urandom_range(0, 255));
      end
      MUT_COUNT: begin
        line[2] = hex_char(4'($urandom));
        line[3] = hex_char(4'($urandom));
      end
      MUT_TRAIL: repeat ($urandom_range(1, 5)) line.push_back(8'($urandom_range(0, 255)));
      MUT_TYPE: line[1] = 8'($urandom_range(0, 255));
      MUT_LEAD: line[0] = 8'($urandom_range(0, 255));
      default: ;
    endcase
  endfunction

  task automatic send_char(logic [7:0] c, logic last);
    int g;
    g = 0;
    if (!calm && sender_gaps && $urandom_range(0, 7) == 0) g = $urandom_range(1, 9);
    if (g > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line[i]) send_char(line[i], i == line.size() - 1);
  endtask

  // hold off until every pending word has drained, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.parsed_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cur_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_record();
    logic [3:0] t;
    int al, ndata;
    flaw_t f;
    case ($urandom_range(0, 9))
      0: t = REC_S0;
      1, 2: t = REC_S1;
      3, 4: t = REC_S2;
      5, 6: t = REC_S3;
      7: t = REC_S7;
      8: t = REC_S8;
      default: t = REC_S9;
    endcase
    al = sb.addr_bytes(t);
    if ($urandom_range(0, 59) == 0) ndata = $urandom_range(0, 254 - al);
    else ndata = $urandom_range(0, 6);
    compose(t, ndata, pick_addr(al));
    f = ($urandom_range(0, 9) < 7) ? MUT_NONE : flaw_t'($urandom_range(1, 6));
    apply_flaw(f);
    send_line();
  endtask

  initial begin : stimulus
    byte unsigned odd_types[5];
    logic [31:0] v;
    int target;
    odd_types = '{"4", "5", "6", "A", "x"};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    compose(REC_S0, 3, '0);
    send_line();
    compose(REC_S1, 2, 32'h0000);
    send_line();
    compose(REC_S3, 3, 32'hFFFF_FFFE);
    send_line();
    compose(REC_S2, 1, 32'hFF_FFFF);
    send_line();
    compose(REC_S7, 0, 32'h8000_0001);
    send_line();
    compose(REC_S8, 0, 32'h12_3456);
    send_line();
    compose(REC_S9, 0, 32'hFFFF);
    send_line();
    foreach (odd_types[i]) begin
      compose(REC_S1, 1, '0);
      line[1] = odd_types[i];
      send_line();
    end
    line.delete();
    line.push_back("S");
    send_line();
    line.push_back(CH_0 + REC_S9);
    send_line();
    compose(REC_S1, 2, '0);
    line[8] = "G";
    send_line();
    compose(REC_S2, 1, '0);
    line[2] = "z";
    send_line();
    compose(REC_S9, 0, 32'h0100);
    line[0] = "X";
    send_line();
    compose(REC_S1, 3, '0);
    line[2] = CH_0;
    line[3] = CH_0 + 8'd2;
    send_line();

    settle();
    write_limit(32'h0000_8000);
    compose(REC_S1, 1, 32'h7FFF);
    send_line();
    compose(REC_S1, 1, 32'h8000);
    send_line();
    compose(REC_S1, 2, 32'h0001);
    line[8] = "G";
    send_line();

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: v = '0;
        1: v = 32'hFFFF_FFFF;
        2: v = $urandom_range(0, 32'hFF_FFFF);
        3: v = $urandom;
        4: v = 32'h0000_1000;
        default: v = $urandom_range(0, 32'hFFFF);
      endcase
      write_limit(v);
      sender_gaps = $urandom_range(0, 3) != 0;
      if (ph == 5) calm = 1'b1;
      target = chars_sent + 80;
      while (chars_sent < target) random_record();
    end

    settle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/srlp_pkg.sv
rtl/core/srlp_parse.sv
rtl/core/srlp_outq.sv
rtl/core/srecord_loader_parser.sv
verif/tb_top.sv
